// ===== rtl/core/hpw_pkg.sv =====
// Shared types and constants of the high-pass window filter.
package hpw_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Register reset values
  localparam logic [2:0]       KERNEL_RESET = 3'd3;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd512;

  typedef logic [PIX_W-1:0] pixel_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_EDGE     = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  // Coordinates and frame marker that travel with a result
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } hpw_meta_t;

  // Per-cell shift control of the window row
  typedef struct packed {
    logic shift;
    logic load_next;
    logic load_new;
  } hpw_cell_ctrl_t;

endpackage

// ===== rtl/core/hpw_line_store.sv =====
// Line stores: one single-port-per-side memory per buffered row, registered read.
module hpw_line_store #(
  parameter int ROWS  = 6,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  input  logic                                 wr_en,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic [ROWS-1:0]                      wr_mask,
  input  logic [ROWS-1:0][hpw_pkg::PIX_W-1:0]  wr_data,
  output logic [ROWS-1:0][hpw_pkg::PIX_W-1:0]  rd_data
);
  import hpw_pkg::*;

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    pixel_t mem [DEPTH];
    pixel_t rd_q;

    // Write the shifted column entry, read the next column
    always_ff @(posedge clk) begin
      if (wr_en && wr_mask[r]) begin
        mem[wr_addr] <= wr_data[r];
      end
      if (rd_en) begin
        rd_q <= mem[rd_addr];
      end
    end

    assign rd_data[r] = rd_q;
  end

endmodule

// ===== rtl/core/hpw_window_cell.sv =====
// One window column cell: holds a column of pixels and forms its masked sum.
module hpw_window_cell #(
  parameter int ROWS = 7
) (
  input  logic                                clk,
  input  hpw_pkg::hpw_cell_ctrl_t             ctrl,
  input  logic [$clog2(ROWS+1)-1:0]           k,
  input  logic [ROWS-1:0][hpw_pkg::PIX_W-1:0] col_next,
  input  logic [ROWS-1:0][hpw_pkg::PIX_W-1:0] col_new,
  output logic [ROWS-1:0][hpw_pkg::PIX_W-1:0] col,
  output logic [$clog2(ROWS*255+1)-1:0]       col_sum
);
  import hpw_pkg::*;

  localparam int KW = $clog2(ROWS + 1);
  localparam int SW = $clog2(ROWS * 255 + 1);

  logic [SW-1:0] acc;

  // Take the neighbor's column or the new column on each shift
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int y = 0; y < ROWS; y++) begin
        if (KW'(y) < k) begin
          if (ctrl.load_next) begin
            col[y] <= col_next[y];
          end else if (ctrl.load_new) begin
            col[y] <= col_new[y];
          end
        end
      end
    end
  end

  // Sum the active rows of this column
  always_comb begin
    acc = '0;
    for (int y = 0; y < ROWS; y++) begin
      if (KW'(y) < k) begin
        acc = acc + SW'(col[y]);
      end
    end
    col_sum = acc;
  end

endmodule

// ===== rtl/core/hpw_score.sv =====
// Score pipeline: window sum, centre weighting, clamp and output register.
module hpw_score #(
  parameter int NK = 7
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [NK-1:0][$clog2(NK*255+1)-1:0]     col_sum,
  input  logic [hpw_pkg::PIX_W-1:0]               centre,
  input  logic [$clog2(NK+1)-1:0]                 k,
  input  hpw_pkg::hpw_meta_t                      meta,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [hpw_pkg::PIX_W-1:0]               filtered,
  output hpw_pkg::hpw_meta_t                      out_meta
);
  import hpw_pkg::*;

  localparam int KW  = $clog2(NK + 1);
  localparam int CSW = $clog2(NK * 255 + 1);
  localparam int KKW = $clog2(NK * NK + 1);
  localparam int TW  = $clog2(NK * NK * 255 + 1);

  logic                    v3, v4;
  logic                    free_o, free4, free3;
  logic [NK-1:0][CSW-1:0]  cs3;
  pixel_t                  centre3;
  logic [KKW-1:0]          kk3;
  logic [KW-1:0]           k3;
  hpw_meta_t               meta3, meta4;
  logic [TW-1:0]           total_c, prod_c, total4, prod4;
  logic [TW:0]             diff;

  assign free_o   = !out_valid || out_ready;
  assign free4    = !v4 || free_o;
  assign free3    = !v3 || free4;
  assign in_ready = free3;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free3) begin
        v3 <= in_valid;
      end
      if (free4) begin
        v4 <= v3;
      end
      if (free_o) begin
        out_valid <= v4;
      end
    end
  end

  // Add the active column sums, weight the centre
  always_comb begin
    total_c = '0;
    for (int x = 0; x < NK; x++) begin
      if (KW'(x) < k3) begin
        total_c = total_c + TW'(cs3[x]);
      end
    end
    prod_c = TW'(kk3) * TW'(centre3);
    diff   = {1'b0, prod4} - {1'b0, total4};
  end

  // Hold or advance stage data
  always_ff @(posedge clk) begin
    if (free3 && in_valid) begin
      cs3     <= col_sum;
      centre3 <= centre;
      kk3     <= KKW'(k) * KKW'(k);
      k3      <= k;
      meta3   <= meta;
    end
    if (free4 && v3) begin
      total4 <= total_c;
      prod4  <= prod_c;
      meta4  <= meta3;
    end
    if (free_o && v4) begin
      out_meta <= meta4;
      if (diff[TW]) begin
        filtered <= '0;
      end else if (|diff[TW-1:PIX_W]) begin
        filtered <= PIX_MAX;
      end else begin
        filtered <= diff[PIX_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/high_pass_window_filter_unit.sv =====
// High-pass window filter: pixel stream in, clamped K x K high-pass results out.
//
// Pixels arrive in raster order on in_valid / in_ready / pixel; each transfer
// moves one pixel. Row and column counters run inside the block, so a frame
// is simply image_width * image_height consecutive transfers.
// Results leave on out_valid / out_ready with filtered, out_row, out_col and
// frame_last; only interior centres whose K x K window is complete produce a
// result, and frame_last marks the last one of the frame. Border pixels get
// no result.
// Configuration (win_edge, image_width, image_height) is written through
// cfg_write / cfg_index / cfg_data between frames while the block is idle.
// A result is registered through the read, window and score stages after
// the transfer of the pixel that completes its window. Throughput: one pixel
// per cycle while the receiver keeps up, set by one read and one write of
// the line stores per column and one shift of the window row. Reset clears
// the counters and empties the pipeline; registers go to K = 3, 512 x 512.
// Line stores are not cleared; stale entries only feed windows with no result.
// A receiver stall backs results up; in_ready drops once every stage is full.
module high_pass_window_filter_unit #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpw_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hpw_pkg::PIX_W-1:0]     pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hpw_pkg::PIX_W-1:0]     filtered,
  output logic [hpw_pkg::COORD_W-1:0]   out_row,
  output logic [hpw_pkg::COORD_W-1:0]   out_col,
  output logic                          frame_last
);
  import hpw_pkg::*;

  localparam int NK      = (MAX_KERNEL - 1) | 1;
  localparam int KW      = $clog2(NK + 1);
  localparam int IW      = $clog2(NK);
  localparam int LS_ROWS = NK - 1;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WW      = CW + 1;
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int HW      = RW + 1;
  localparam int CSW     = $clog2(NK * 255 + 1);

  // Configuration registers
  logic [2:0]       win_edge;
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  // Effective settings
  logic [2:0]    k_raw;
  logic [KW-1:0] k_eff, off;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // Counters and current position
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          wrap_c;
  logic [CW-1:0] c_cur;
  logic [HW-1:0] r_tmp;
  logic [RW-1:0] r_cur;
  logic [WW-1:0] c_inc;
  logic [HW-1:0] r_inc;
  logic          col_end, row_end, keep;
  hpw_meta_t     meta_c;

  // Pipeline
  logic                          accept;
  logic                          v1, v2, adv1, adv2, free2, s_ready;
  pixel_t                        px1;
  logic [CW-1:0]                 c1;
  logic                          keep1;
  hpw_meta_t                     meta1, meta2, meta_o;
  logic [LS_ROWS-1:0][PIX_W-1:0] ls_rd, ls_wdata;
  logic [LS_ROWS-1:0]            ls_wmask;
  logic [NK-1:0][PIX_W-1:0]      column;
  logic [NK-1:0][NK-1:0][PIX_W-1:0] cell_col;
  logic [NK-1:0][CSW-1:0]        col_sum;
  hpw_cell_ctrl_t [NK-1:0]       cell_ctrl;
  pixel_t                        centre;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_edge     <= KERNEL_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIN_EDGE:     win_edge     <= cfg_data[2:0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp settings to the supported ranges
  always_comb begin
    k_raw = win_edge | 3'd1;
    if (k_raw < 3'd3) begin
      k_eff = KW'(3);
    end else if (32'(k_raw) > NK) begin
      k_eff = KW'(NK);
    end else begin
      k_eff = KW'(k_raw);
    end
    off = k_eff >> 1;

    if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (image_width < 11'd3) begin
      w_eff = WW'(3);
    end else begin
      w_eff = WW'(image_width);
    end

    if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else if (image_height < 11'd3) begin
      h_eff = HW'(3);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  // Position of the incoming pixel, wrapping counters left beyond a new size
  always_comb begin
    wrap_c  = WW'(col) >= w_eff;
    c_cur   = wrap_c ? '0 : col;
    r_tmp   = HW'(row) + HW'(wrap_c);
    r_cur   = (r_tmp >= h_eff) ? '0 : r_tmp[RW-1:0];
    c_inc   = WW'(c_cur) + WW'(1);
    r_inc   = HW'(r_cur) + HW'(1);
    col_end = c_inc >= w_eff;
    row_end = r_inc >= h_eff;
    keep    = (r_inc >= HW'(k_eff)) && (c_inc >= WW'(k_eff));
    meta_c.row  = COORD_W'(r_cur - RW'(off));
    meta_c.col  = COORD_W'(c_cur - CW'(off));
    meta_c.last = (r_inc == h_eff) && (c_inc == w_eff);
  end

  // Handshake through the front stages
  assign free2    = !v2 || s_ready;
  assign adv1     = v1 && free2;
  assign adv2     = v2 && s_ready;
  assign in_ready = !v1 || free2;
  assign accept   = in_valid && in_ready;

  // Advance counters and front-stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      if (accept) begin
        if (col_end) begin
          col <= '0;
          row <= row_end ? '0 : r_inc[RW-1:0];
        end else begin
          col <= c_inc[CW-1:0];
          row <= r_cur;
        end
      end
      if (accept) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= keep1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
    end
  end

  // Hold the accepted pixel while its column is read
  always_ff @(posedge clk) begin
    if (accept) begin
      px1   <= pixel;
      c1    <= c_cur;
      keep1 <= keep;
      meta1 <= meta_c;
    end
    if (adv1) begin
      meta2 <= meta1;
    end
  end

  hpw_line_store #(
    .ROWS  (LS_ROWS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .wr_en   (adv1),
    .wr_addr (c1),
    .wr_mask (ls_wmask),
    .wr_data (ls_wdata),
    .rd_data (ls_rd)
  );

  // Build the new window column and the shifted line-store entries
  always_comb begin
    for (int y = 0; y < LS_ROWS; y++) begin
      column[y] = (KW'(y + 1) < k_eff) ? ls_rd[y] : px1;
    end
    column[NK-1] = px1;
    for (int y = 0; y < LS_ROWS; y++) begin
      ls_wdata[y] = column[y + 1];
      ls_wmask[y] = KW'(y + 1) < k_eff;
    end
    for (int x = 0; x < NK; x++) begin
      cell_ctrl[x].shift     = adv1;
      cell_ctrl[x].load_next = KW'(x + 1) < k_eff;
      cell_ctrl[x].load_new  = KW'(x + 1) == k_eff;
    end
  end

  // Row of window cells, each shifting left into its neighbor
  for (genvar x = 0; x < NK; x++) begin : g_cell
    if (x < NK - 1) begin : g_mid
      hpw_window_cell #(.ROWS(NK)) u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[x]),
        .k        (k_eff),
        .col_next (cell_col[x+1]),
        .col_new  (column),
        .col      (cell_col[x]),
        .col_sum  (col_sum[x])
      );
    end else begin : g_end
      hpw_window_cell #(.ROWS(NK)) u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[x]),
        .k        (k_eff),
        .col_next (column),
        .col_new  (column),
        .col      (cell_col[x]),
        .col_sum  (col_sum[x])
      );
    end
  end

  assign centre = cell_col[off[IW-1:0]][off[IW-1:0]];

  hpw_score #(.NK(NK)) u_score (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (s_ready),
    .col_sum   (col_sum),
    .centre    (centre),
    .k         (k_eff),
    .meta      (meta2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .out_meta  (meta_o)
  );

  assign out_row    = meta_o.row;
  assign out_col    = meta_o.col;
  assign frame_last = meta_o.last;

`ifndef SYNTH
  // A transfer always fills the read stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted pixel did not enter the read stage");

  // An interior pixel leaving the read stage becomes a pending score
  a_keep_scores: assert property (@(posedge clk) disable iff (rst)
    (adv1 && keep1) |=> v2)
    else $error("interior window lost before scoring");

  // Reset empties the front stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!v1 && !v2))
    else $error("front stages not empty after reset");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the high-pass window filter unit.
`timescale 1ns / 100ps

module tb;
  import hpw_pkg::*;

  localparam int MAXK  = 7;
  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int KMAX  = (MAXK - 1) | 1;

  // One filtered centre as it leaves the block
  typedef struct packed {
    pixel_t    value;
    hpw_meta_t meta;
  } centre_t;

  // One row of the directed plan: pixel, whether a result is typed in, and that result
  typedef struct packed {
    pixel_t  px;
    logic    typed;
    centre_t res;
  } plan_row_t;

  localparam centre_t NONE = '0;
  localparam centre_t PEAK = {8'd255, 10'd1, 10'd1, 1'b1};
  localparam centre_t PIT  = {8'd0, 10'd1, 10'd1, 1'b1};
  localparam int PLAN_ROWS = 18;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  pixel_t             pixel;
  logic               out_valid;
  logic               out_ready;
  pixel_t             filtered;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               frame_last;

  // Typed-in expectation that travels with the current pixel
  logic    typed_valid;
  centre_t typed_res;

  // Filter state mirrored from the block
  pixel_t     line_mem [MAXK-1][MAX_W];
  pixel_t     win_mem [MAXK][MAXK];
  int         row_cnt;
  int         col_cnt;
  logic [2:0] kern_reg;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  centre_t pending_centres [$];

  int  errors;
  int  pixels_sent;
  int  results_checked;
  int  settings_run;
  bit  calm;
  bit  squeeze_req;
  bit  squeezed;
  int  hold_left;

  plan_row_t plan [PLAN_ROWS] = '{
    {8'd0, 1'b0, NONE}, {8'd0, 1'b0, NONE}, {8'd0, 1'b0, NONE},
    {8'd0, 1'b0, NONE}, {8'd255, 1'b0, NONE}, {8'd0, 1'b0, NONE},
    {8'd0, 1'b0, NONE}, {8'd0, 1'b0, NONE}, {8'd0, 1'b1, PEAK},
    {8'd255, 1'b0, NONE}, {8'd255, 1'b0, NONE}, {8'd255, 1'b0, NONE},
    {8'd255, 1'b0, NONE}, {8'd0, 1'b0, NONE}, {8'd255, 1'b0, NONE},
    {8'd255, 1'b0, NONE}, {8'd255, 1'b0, NONE}, {8'd255, 1'b1, PIT}
  };

  high_pass_window_filter_unit #(
    .MAX_KERNEL(MAXK),
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .out_row   (out_row),
    .out_col   (out_col),
    .frame_last(frame_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Clamp a size register to the range the block uses
  function automatic int eff_size(input logic [CFG_W-1:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Advance the filter by one pixel; return 1 when a window completes
  function automatic bit hp_filter_pixel(input pixel_t px, output centre_t res);
    int k, w, h, off, r, c, x, y, sum, val;
    pixel_t column [MAXK];
    bit hit;
    k = int'(kern_reg | 3'd1);
    if (k < 3) k = 3;
    if (k > KMAX) k = KMAX;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    off = k / 2;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    // Build the new window column and push it up the line stores
    for (y = 0; y + 1 < k; y++) column[y] = line_mem[y][c];
    column[k-1] = px;
    for (y = 0; y + 1 < k; y++) line_mem[y][c] = column[y+1];
    // Shift the window left and drop the new column in on the right
    for (y = 0; y < k; y++) begin
      for (x = 0; x + 1 < k; x++) win_mem[y][x] = win_mem[y][x+1];
      win_mem[y][k-1] = column[y];
    end
    hit = 1'b0;
    res = '0;
    if (r + 1 >= k && c + 1 >= k) begin
      sum = 0;
      for (y = 0; y < k; y++)
        for (x = 0; x < k; x++) sum += int'(win_mem[y][x]);
      val = k * k * int'(win_mem[off][off]) - sum;
      if (val < 0) val = 0;
      if (val > 255) val = 255;
      res.value     = pixel_t'(val);
      res.meta.row  = COORD_W'(r - off);
      res.meta.col  = COORD_W'(c - off);
      res.meta.last = (r + 1 == h) && (c + 1 == w);
      hit = 1'b1;
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    return hit;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Predict on every input transfer, check on every output transfer
  always @(posedge clk) begin : monitor
    centre_t res;
    centre_t want;
    bit hit;
    if (!rst) begin
      if (in_valid && in_ready) begin
        hit = hp_filter_pixel(pixel, res);
        if (typed_valid) pending_centres.push_back(typed_res);
        else if (hit) pending_centres.push_back(res);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_centres.size() == 0) begin
          note_error($sformatf("unexpected result value %0d row %0d col %0d last %0b",
                               filtered, out_row, out_col, frame_last));
        end else begin
          want = pending_centres.pop_front();
          if (filtered !== want.value || out_row !== want.meta.row ||
              out_col !== want.meta.col || frame_last !== want.meta.last)
            note_error($sformatf(
              "result %0d: want %0d row %0d col %0d last %0b, got %0d row %0d col %0d last %0b",
              results_checked, want.value, want.meta.row, want.meta.col, want.meta.last,
              filtered, out_row, out_col, frame_last));
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a calm stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (squeeze_req && !squeezed && out_valid) begin
        squeezed  = 1'b1;
        hold_left = 300;
      end
      out_ready <= !rst && hold_left == 0 && (calm || $urandom_range(0, 99) >= 23);
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("high_pass_window_filter_unit verification failed");
    $finish;
  end

  // Write one register; leaves cfg_write high for the caller to drop
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      CFG_WIN_EDGE:     kern_reg = d[2:0];
      CFG_IMAGE_WIDTH:  width_reg = d;
      CFG_IMAGE_HEIGHT: height_reg = d;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_config(input logic [2:0] k, input logic [CFG_W-1:0] w,
                              input logic [CFG_W-1:0] h, input bit with_kernel);
    if (with_kernel) write_reg(CFG_WIN_EDGE, {{(CFG_W-3){1'b0}}, k});
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // Offer one pixel, idling first at random, and hold it until the transfer
  task automatic send_pixel(input pixel_t p, input bit tv, input centre_t tres);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= p;
    typed_valid <= tv;
    typed_res   <= tres;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  // Stop offering and wait until every expected centre has come out
  task automatic drain(input int settle);
    in_valid    <= 1'b0;
    typed_valid <= 1'b0;
    do @(negedge clk); while (pending_centres.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Program one setting and stream whole frames through it
  task automatic stream_frames(input logic [2:0] k, input logic [CFG_W-1:0] w,
                               input logic [CFG_W-1:0] h, input int frames,
                               input int pause_at);
    int total, n, mode, base, v;
    write_config(k, w, h, 1'b1);
    settings_run++;
    total = frames * eff_size(w, MAX_W) * eff_size(h, MAX_H);
    mode  = $urandom_range(0, 2);
    base  = $urandom_range(8, 247);
    for (n = 0; n < total; n++) begin
      if (n == pause_at) drain(0);
      case (mode)
        0:       v = $urandom_range(0, 255);
        1:       v = $urandom_range(0, 1) ? 255 : 0;
        default: v = base + $urandom_range(0, 16) - 8;
      endcase
      send_pixel(pixel_t'(v), 1'b0, NONE);
    end
    drain(10);
  endtask

  // Mostly small sizes, now and then one below the legal floor
  function automatic logic [CFG_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, 2));
    return CFG_W'($urandom_range(3, 16));
  endfunction

  initial begin
    int i;
    int j;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = CFG_WIN_EDGE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    pixel       = '0;
    typed_valid = 1'b0;
    typed_res   = NONE;
    errors          = 0;
    pixels_sent     = 0;
    results_checked = 0;
    settings_run    = 0;
    calm        = 1'b0;
    squeeze_req = 1'b0;
    squeezed    = 1'b0;
    hold_left   = 0;
    for (i = 0; i < MAXK - 1; i++)
      for (j = 0; j < MAX_W; j++) line_mem[i][j] = '0;
    for (i = 0; i < MAXK; i++)
      for (j = 0; j < MAXK; j++) win_mem[i][j] = '0;
    row_cnt    = 0;
    col_cnt    = 0;
    kern_reg   = KERNEL_RESET;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: two 3x3 frames on the reset kernel, bright peak then dark pit
    write_config(3'd0, 11'd3, 11'd3, 1'b0);
    for (i = 0; i < PLAN_ROWS; i++)
      send_pixel(plan[i].px, plan[i].typed, plan[i].res);
    drain(10);

    // Setting extremes: small and large kernel codes, undersized image, sizes below the floor
    stream_frames(3'd0, 11'd1, 11'd2, 2, -1);
    stream_frames(3'd7, 11'd7, 11'd7, 1, -1);
    stream_frames(3'd6, 11'd5, 11'd9, 1, -1);
    squeeze_req = 1'b1;
    stream_frames(3'd1, 11'd30, 11'd3, 1, -1);
    calm = 1'b1;
    stream_frames(3'd2, 11'd3, 11'd100, 1, 150);
    calm = 1'b0;
    stream_frames(3'd4, 11'd40, 11'd8, 1, -1);

    // Random settings with whole frames of random content
    while (pixels_sent < 1600)
      stream_frames(3'($urandom_range(0, 7)), pick_size(), pick_size(),
                    $urandom_range(1, 2), -1);

    repeat (20) @(negedge clk);
    if (pending_centres.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_centres.size()));
    $display("Streamed %0d pixels over %0d filter settings; %0d filtered centres checked.",
             pixels_sent, settings_run, results_checked);
    $display("Kernels 3 to 7, image sides from below the floor up to 100, %0d errors.",
             errors);
    if (errors == 0) begin
      $display("high_pass_window_filter_unit verification clean");
    end else begin
      $display("high_pass_window_filter_unit verification failed");
    end
    $finish;
  end

endmodule
